// ===== hw/rtl/psm_pkg.sv =====
// ----------------------------------------------------------------------------
// psm_pkg
// shared constants, opcode and status codes, controller/datapath signal groups
// ----------------------------------------------------------------------------
package psm_pkg;

	localparam int DATA_STACK_DEPTH = 64;
	localparam int CALL_STACK_DEPTH = 32;
	localparam int STATIC_WORDS     = 256;
	localparam int CODE_WORDS       = 4096;
	localparam int WORD_BITS        = 64;

	localparam int DSTK_AW = $clog2(DATA_STACK_DEPTH);
	localparam int DCNT_W  = $clog2(DATA_STACK_DEPTH + 1);
	localparam int RSTK_AW = $clog2(CALL_STACK_DEPTH);
	localparam int RCNT_W  = $clog2(CALL_STACK_DEPTH + 1);
	localparam int SADDR_W = $clog2(STATIC_WORDS);
	localparam int CODE_AW = $clog2(CODE_WORDS);
	localparam int HALF_W  = WORD_BITS / 2;
	localparam int SHAMT_W = $clog2(WORD_BITS);

	typedef enum logic [5:0] {
		OP_ADD        = 6'd0,
		OP_SUB        = 6'd1,
		OP_MUL        = 6'd2,
		OP_DIV        = 6'd3,
		OP_MOD        = 6'd4,
		OP_SHL        = 6'd5,
		OP_SHR        = 6'd6,
		OP_AND        = 6'd7,
		OP_OR         = 6'd8,
		OP_XOR        = 6'd9,
		OP_COMPLEMENT = 6'd10,
		OP_LOGAND     = 6'd11,
		OP_LOGOR      = 6'd12,
		OP_LOGNOT     = 6'd13,
		OP_DUP        = 6'd14,
		OP_DUP2       = 6'd15,
		OP_OVER       = 6'd16,
		OP_OVER2      = 6'd17,
		OP_SWAP       = 6'd18,
		OP_SWAP2      = 6'd19,
		OP_FETCH      = 6'd20,
		OP_STORE      = 6'd21,
		OP_GOTO       = 6'd22,
		OP_GOTO0      = 6'd23,
		OP_CALL       = 6'd24,
		OP_RETURN     = 6'd25,
		OP_SYSCALL    = 6'd26,
		OP_CONST      = 6'd27,
		OP_DROP       = 6'd28,
		OP_DROP2      = 6'd29,
		OP_SYSRETURN  = 6'd30,
		OP_INPUT      = 6'd31,
		OP_OUTPUT     = 6'd32,
		OP_DATAMEM    = 6'd33,
		OP_CODEMEM    = 6'd34,
		OP_STARTUSER  = 6'd35,
		OP_TERMINATE  = 6'd36
	} op_t;

	typedef enum logic [3:0] {
		ST_RUN     = 4'd0,
		ST_HALT    = 4'd1,
		ST_ILLEGAL = 4'd2,
		ST_PRIV    = 4'd3,
		ST_BADARG  = 4'd4,
		ST_BADSYS  = 4'd5,
		ST_ADDR    = 4'd6,
		ST_STACK   = 4'd7,
		ST_DIVZ    = 4'd8
	} status_t;

	typedef enum logic [1:0] {
		RD_TOP    = 2'd0,
		RD_SECOND = 2'd1,
		RD_THIRD  = 2'd2
	} rd_sel_t;

	// controller -> datapath
	typedef struct packed {
		logic    load;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    cap0;
		logic    cap1;
		logic    cap2;
		logic    md_start;
		logic    exec;
		logic    wb;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_md;
		logic md_done;
	} stat_t;

endpackage

// ===== hw/rtl/privileged_stack_machine_core.sv =====
// ----------------------------------------------------------------------------
// privileged_stack_machine_core
// 64-bit stack machine executing one instruction per input item
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_ready) carries one instruction per item: the
//   opcode, the code word after it and a console value for input/syscall
//   output channel (res_valid/res_ready) returns one result item per
//   instruction: next fetch address, console output, status and mode
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes the start mode bit,
//   which also loads the current mode; taken only while idle
// timing:
//   most instructions pass from acceptance to the next acceptance through
//   three data stack memory reads plus the static store read, execute and a
//   second stack write; the result is valid the cycle after execute
//   multiply adds a wait for three 32x32 partial products on one multiplier,
//   divide and modulo a wait of one quotient bit per cycle
// reset:
//   ip, stack counts, bounds and halt clear, supervisor mode is entered,
//   the static store reads as zero until written
// stall:
//   a result waiting on res_ready holds the next instruction at execute;
//   in_ready stays low until that instruction has finished
// ----------------------------------------------------------------------------
module privileged_stack_machine_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [5:0]                           action,
	input  logic signed [31:0]                   inline_word,
	input  logic signed [31:0]                   read_value,
	output logic                                 res_valid,
	input  logic                                 res_ready,
	output logic [psm_pkg::CODE_AW-1:0]          fetch_ip,
	output logic                                 out_valid,
	output logic signed [psm_pkg::WORD_BITS-1:0] out_value,
	output logic [3:0]                           status,
	output logic                                 supervisor,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic                                 cfg_data
);
	import psm_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// sequencer: one instruction at a time
	psm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.cfg_ready (cfg_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// state, stacks, static store and execute logic
	psm_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.action      (action),
		.inline_word (inline_word),
		.read_value  (read_value),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_data    (cfg_data),
		.fetch_ip    (fetch_ip),
		.out_valid   (out_valid),
		.out_value   (out_value),
		.status      (status),
		.supervisor  (supervisor)
	);

endmodule

// ===== hw/rtl/psm_muldiv.sv =====
// ----------------------------------------------------------------------------
// psm_muldiv
// multi-cycle multiply (32x32 partial products) and radix-2 signed divide
// ----------------------------------------------------------------------------
module psm_muldiv (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           mul_sel,
	input  logic                           mod_sel,
	input  logic [psm_pkg::WORD_BITS-1:0]  a,
	input  logic [psm_pkg::WORD_BITS-1:0]  b,
	output logic                           done,
	output logic [psm_pkg::WORD_BITS-1:0]  result
);
	import psm_pkg::*;

	typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV, M_FIX} md_state_t;

	md_state_t              state_q;
	logic [SHAMT_W-1:0]     cnt_q;
	logic [WORD_BITS-1:0]   a_q, b_q, acc_q, prod_q;
	logic [WORD_BITS-1:0]   quo_q, rem_q, dvs_q;
	logic                   qneg_q, rneg_q, mod_q, done_q;
	logic [WORD_BITS-1:0]   res_q;
	logic [HALF_W-1:0]      mx, my;
	logic [WORD_BITS-1:0]   mprod;
	logic [WORD_BITS-1:0]   shifted, diff;
	logic                   fits;

	// one shared 32x32 multiplier, operands picked by step
	always_comb begin
		mx = a_q[HALF_W-1:0];
		my = b_q[HALF_W-1:0];
		case (cnt_q)
			SHAMT_W'(1): my = b_q[WORD_BITS-1:HALF_W];
			SHAMT_W'(2): mx = a_q[WORD_BITS-1:HALF_W];
			default: ;
		endcase
		mprod = mx * my;
	end

	assign shifted = {rem_q[WORD_BITS-2:0], quo_q[WORD_BITS-1]};
	assign fits    = shifted >= dvs_q;
	assign diff    = shifted - dvs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				M_IDLE: begin
					cnt_q <= '0;
					if (start) state_q <= mul_sel ? M_MUL : M_DIV;
				end
				M_MUL: begin
					cnt_q <= cnt_q + SHAMT_W'(1);
					if (cnt_q == SHAMT_W'(3)) begin
						done_q  <= 1'b1;
						state_q <= M_IDLE;
					end
				end
				M_DIV: begin
					cnt_q <= cnt_q + SHAMT_W'(1);
					if (cnt_q == SHAMT_W'(WORD_BITS - 1)) state_q <= M_FIX;
				end
				M_FIX: begin
					done_q  <= 1'b1;
					state_q <= M_IDLE;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == M_IDLE && start) begin
			a_q    <= a;
			b_q    <= b;
			mod_q  <= mod_sel;
			qneg_q <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
			rneg_q <= a[WORD_BITS-1];
			quo_q  <= a[WORD_BITS-1] ? (~a + WORD_BITS'(1)) : a;
			dvs_q  <= b[WORD_BITS-1] ? (~b + WORD_BITS'(1)) : b;
			rem_q  <= '0;
		end
		if (state_q == M_MUL) begin
			prod_q <= mprod;
			case (cnt_q)
				SHAMT_W'(0): acc_q <= '0;
				SHAMT_W'(1): acc_q <= prod_q;
				SHAMT_W'(2): acc_q <= acc_q + {prod_q[HALF_W-1:0], {HALF_W{1'b0}}};
				default:     res_q <= acc_q + {prod_q[HALF_W-1:0], {HALF_W{1'b0}}};
			endcase
		end
		if (state_q == M_DIV) begin
			rem_q <= fits ? diff : shifted;
			quo_q <= {quo_q[WORD_BITS-2:0], fits};
		end
		if (state_q == M_FIX) begin
			if (mod_q) res_q <= rneg_q ? (~rem_q + WORD_BITS'(1)) : rem_q;
			else       res_q <= qneg_q ? (~quo_q + WORD_BITS'(1)) : quo_q;
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

// ===== hw/rtl/psm_dp.sv =====
// ----------------------------------------------------------------------------
// psm_dp
// architectural state, stacks, static store and instruction execution
// ----------------------------------------------------------------------------
module psm_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  psm_pkg::cmd_t                      cmd,
	output psm_pkg::stat_t                     stat,
	input  logic [5:0]                         action,
	input  logic signed [31:0]                 inline_word,
	input  logic signed [31:0]                 read_value,
	input  logic                               cfg_we,
	input  logic                               cfg_data,
	output logic [psm_pkg::CODE_AW-1:0]        fetch_ip,
	output logic                               out_valid,
	output logic signed [psm_pkg::WORD_BITS-1:0] out_value,
	output logic [3:0]                         status,
	output logic                               supervisor
);
	import psm_pkg::*;

	// architectural state
	logic [CODE_AW-1:0]   ip_q, code_lo_q, code_hi_q;
	logic [SADDR_W-1:0]   data_lo_q, data_hi_q;
	logic [DCNT_W-1:0]    dcnt_q;
	logic [RCNT_W-1:0]    rcnt_q;
	logic                 mode_q, halted_q;
	logic [STATIC_WORDS-1:0] svalid_q;

	logic [WORD_BITS-1:0] dstk [DATA_STACK_DEPTH];
	logic [WORD_BITS-1:0] sstore [STATIC_WORDS];
	logic [CODE_AW-1:0]   rstk_q [CALL_STACK_DEPTH];

	// operands of the item in flight
	op_t                  op_q;
	logic [31:0]          iw_q, rv_q;
	logic [WORD_BITS-1:0] rdata_q, t0_q, t1_q, t2_q, srd_q;
	logic                 srd_v_q;
	logic                 w2_en_q;
	logic [DSTK_AW-1:0]   w2_addr_q;
	logic [WORD_BITS-1:0] w2_data_q;

	// result registers
	logic [CODE_AW-1:0]   fetch_ip_q;
	logic                 emit_q, sup_q;
	logic [WORD_BITS-1:0] oval_q;
	status_t              st_q;

	logic [DCNT_W-1:0]    n_m1, n_m2, n_m3, n_p1;
	logic [RCNT_W-1:0]    rc_m1;
	logic [DSTK_AW-1:0]   rd_addr;
	logic [CODE_AW-1:0]   rtop;
	logic [WORD_BITS-1:0] iw_x, rv_x, sfetch, alu_r, md_res;
	logic                 md_done, iw_ok, t0_data_ok, rtop_ok, sh_oob;
	logic                 is_mul, is_divmod;

	// execution plan
	status_t              st;
	logic [CODE_AW-1:0]   nip;
	logic [DCNT_W-1:0]    ncnt;
	logic [RCNT_W-1:0]    nrc;
	logic                 nmode, emit, w1_en, w2_en, s_we, rs_push;
	logic [WORD_BITS-1:0] oval, w1_data, w2_data;
	logic [DSTK_AW-1:0]   w1_addr, w2_addr;
	logic [CODE_AW-1:0]   nclo, nchi;
	logic [SADDR_W-1:0]   ndlo, ndhi;

	assign n_m1  = dcnt_q - DCNT_W'(1);
	assign n_m2  = dcnt_q - DCNT_W'(2);
	assign n_m3  = dcnt_q - DCNT_W'(3);
	assign n_p1  = dcnt_q + DCNT_W'(1);
	assign rc_m1 = rcnt_q - RCNT_W'(1);
	assign rtop  = rstk_q[rc_m1[RSTK_AW-1:0]];
	assign iw_x  = WORD_BITS'($signed(iw_q));
	assign rv_x  = WORD_BITS'($signed(rv_q));
	assign sfetch = srd_v_q ? srd_q : '0;

	always_comb begin
		case (cmd.rd_sel)
			RD_SECOND: rd_addr = n_m2[DSTK_AW-1:0];
			RD_THIRD:  rd_addr = n_m3[DSTK_AW-1:0];
			default:   rd_addr = n_m1[DSTK_AW-1:0];
		endcase
	end

	assign iw_ok = (iw_q[31:CODE_AW] == '0) && (iw_q[CODE_AW-1:0] >= code_lo_q)
		&& (iw_q[CODE_AW-1:0] <= code_hi_q);
	assign t0_data_ok = (t0_q[WORD_BITS-1:SADDR_W] == '0)
		&& (t0_q[SADDR_W-1:0] >= data_lo_q) && (t0_q[SADDR_W-1:0] <= data_hi_q);
	assign rtop_ok = (rtop >= code_lo_q) && (rtop <= code_hi_q);

	assign is_mul    = (op_q == OP_MUL);
	assign is_divmod = (op_q == OP_DIV) || (op_q == OP_MOD);
	assign stat.need_md = !halted_q && (dcnt_q >= DCNT_W'(2))
		&& (is_mul || (is_divmod && (t0_q != '0)));
	assign stat.md_done = md_done;

	psm_muldiv u_muldiv (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.md_start),
		.mul_sel (is_mul),
		.mod_sel (op_q == OP_MOD),
		.a       (t1_q),
		.b       (t0_q),
		.done    (md_done),
		.result  (md_res)
	);

	// two-operand alu, a is second, b is top
	assign sh_oob = (t0_q[WORD_BITS-1:SHAMT_W] != '0);
	always_comb begin
		case (op_q)
			OP_ADD:    alu_r = t1_q + t0_q;
			OP_SUB:    alu_r = t1_q - t0_q;
			OP_SHL:    alu_r = sh_oob ? '0 : (t1_q << t0_q[SHAMT_W-1:0]);
			OP_SHR:    alu_r = sh_oob ? {WORD_BITS{t1_q[WORD_BITS-1]}}
				: WORD_BITS'($signed(t1_q) >>> t0_q[SHAMT_W-1:0]);
			OP_AND:    alu_r = t1_q & t0_q;
			OP_OR:     alu_r = t1_q | t0_q;
			OP_XOR:    alu_r = t1_q ^ t0_q;
			OP_LOGAND: alu_r = WORD_BITS'((t1_q != '0) && (t0_q != '0));
			OP_LOGOR:  alu_r = WORD_BITS'((t1_q != '0) || (t0_q != '0));
			default:   alu_r = md_res;
		endcase
	end

	always_comb begin
		st      = ST_RUN;
		nip     = ip_q + CODE_AW'(1);
		ncnt    = dcnt_q;
		nrc     = rcnt_q;
		nmode   = mode_q;
		emit    = 1'b0;
		oval    = '0;
		w1_en   = 1'b0;
		w1_addr = n_m1[DSTK_AW-1:0];
		w1_data = t0_q;
		w2_en   = 1'b0;
		w2_addr = n_m2[DSTK_AW-1:0];
		w2_data = t0_q;
		s_we    = 1'b0;
		rs_push = 1'b0;
		nclo    = code_lo_q;
		nchi    = code_hi_q;
		ndlo    = data_lo_q;
		ndhi    = data_hi_q;
		if (halted_q) begin
			st = ST_HALT;
		end else if (op_q >= OP_SYSRETURN && op_q <= OP_TERMINATE && !mode_q) begin
			st = ST_PRIV;
		end else begin
			unique case (op_q)
				OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_SHL, OP_SHR,
				OP_AND, OP_OR, OP_XOR, OP_LOGAND, OP_LOGOR: begin
					if (dcnt_q < DCNT_W'(2)) st = ST_STACK;
					else if (is_divmod && t0_q == '0) st = ST_DIVZ;
					else begin
						w1_en   = 1'b1;
						w1_addr = n_m2[DSTK_AW-1:0];
						w1_data = alu_r;
						ncnt    = n_m1;
					end
				end
				OP_COMPLEMENT, OP_LOGNOT: begin
					if (dcnt_q == '0) st = ST_STACK;
					else begin
						w1_en   = 1'b1;
						w1_data = (op_q == OP_COMPLEMENT) ? ~t0_q : WORD_BITS'(t0_q == '0);
					end
				end
				OP_DUP, OP_OVER, OP_OVER2: begin
					if (dcnt_q < ((op_q == OP_DUP) ? DCNT_W'(1) :
						(op_q == OP_OVER) ? DCNT_W'(2) : DCNT_W'(3))
						|| dcnt_q >= DCNT_W'(DATA_STACK_DEPTH)) st = ST_STACK;
					else begin
						w1_en   = 1'b1;
						w1_addr = dcnt_q[DSTK_AW-1:0];
						w1_data = (op_q == OP_DUP) ? t0_q : (op_q == OP_OVER) ? t1_q : t2_q;
						ncnt    = n_p1;
					end
				end
				OP_DUP2: begin
					if (dcnt_q == '0 || dcnt_q >= DCNT_W'(DATA_STACK_DEPTH - 1)) st = ST_STACK;
					else begin
						w1_en   = 1'b1;
						w1_addr = dcnt_q[DSTK_AW-1:0];
						w2_en   = 1'b1;
						w2_addr = n_p1[DSTK_AW-1:0];
						ncnt    = dcnt_q + DCNT_W'(2);
					end
				end
				OP_SWAP, OP_SWAP2: begin
					if (dcnt_q < ((op_q == OP_SWAP) ? DCNT_W'(2) : DCNT_W'(3))) st = ST_STACK;
					else begin
						w1_en   = 1'b1;
						w1_data = (op_q == OP_SWAP) ? t1_q : t2_q;
						w2_en   = 1'b1;
						w2_addr = (op_q == OP_SWAP) ? n_m2[DSTK_AW-1:0] : n_m3[DSTK_AW-1:0];
					end
				end
				OP_FETCH: begin
					if (dcnt_q == '0) st = ST_STACK;
					else if (!t0_data_ok) st = ST_ADDR;
					else begin
						w1_en   = 1'b1;
						w1_data = sfetch;
					end
				end
				OP_STORE: begin
					if (dcnt_q < DCNT_W'(2)) st = ST_STACK;
					else if (!t0_data_ok) st = ST_ADDR;
					else begin
						s_we = 1'b1;
						ncnt = n_m2;
					end
				end
				OP_GOTO: begin
					if (!iw_ok) st = ST_ADDR;
					else nip = iw_q[CODE_AW-1:0];
				end
				OP_GOTO0: begin
					if (dcnt_q == '0) st = ST_STACK;
					else if (t0_q == '0 && !iw_ok) st = ST_ADDR;
					else begin
						nip  = (t0_q == '0) ? iw_q[CODE_AW-1:0] : ip_q + CODE_AW'(2);
						ncnt = n_m1;
					end
				end
				OP_CALL: begin
					if (rcnt_q >= RCNT_W'(CALL_STACK_DEPTH)) st = ST_STACK;
					else if (!iw_ok) st = ST_ADDR;
					else begin
						rs_push = 1'b1;
						nrc     = rcnt_q + RCNT_W'(1);
						nip     = iw_q[CODE_AW-1:0];
					end
				end
				OP_RETURN, OP_SYSRETURN: begin
					if (rcnt_q == '0) st = ST_STACK;
					else if (!rtop_ok) st = ST_ADDR;
					else begin
						nip = rtop;
						nrc = rc_m1;
						if (op_q == OP_SYSRETURN) nmode = 1'b0;
					end
				end
				OP_SYSCALL: begin
					if (dcnt_q == '0) st = ST_STACK;
					else if (t0_q == WORD_BITS'(0)) begin
						w1_en   = 1'b1;
						w1_data = rv_x;
						nmode   = 1'b1;
					end else if (t0_q == WORD_BITS'(1)) begin
						if (dcnt_q < DCNT_W'(2)) st = ST_STACK;
						else begin
							emit  = 1'b1;
							oval  = t1_q;
							ncnt  = n_m2;
							nmode = 1'b1;
						end
					end else if (t0_q == WORD_BITS'(2)) begin
						// exit call: pop the code, then stop
						ncnt  = n_m1;
						nmode = 1'b1;
						st    = ST_HALT;
					end else begin
						st = ST_BADSYS;
					end
				end
				OP_CONST, OP_INPUT: begin
					if (dcnt_q >= DCNT_W'(DATA_STACK_DEPTH)) st = ST_STACK;
					else begin
						w1_en   = 1'b1;
						w1_addr = dcnt_q[DSTK_AW-1:0];
						w1_data = (op_q == OP_CONST) ? iw_x : rv_x;
						ncnt    = n_p1;
						if (op_q == OP_CONST) nip = ip_q + CODE_AW'(2);
					end
				end
				OP_DROP, OP_DROP2: begin
					if (dcnt_q < ((op_q == OP_DROP) ? DCNT_W'(1) : DCNT_W'(2))) st = ST_STACK;
					else ncnt = (op_q == OP_DROP) ? n_m1 : n_m2;
				end
				OP_OUTPUT: begin
					if (dcnt_q == '0) st = ST_STACK;
					else begin
						emit = 1'b1;
						oval = t0_q;
						ncnt = n_m1;
					end
				end
				OP_DATAMEM, OP_CODEMEM: begin
					if (dcnt_q < DCNT_W'(2)) st = ST_STACK;
					else if ($signed(t1_q) > $signed(t0_q) || t1_q[WORD_BITS-1]
						|| (op_q == OP_DATAMEM && t0_q >= WORD_BITS'(STATIC_WORDS))
						|| (op_q == OP_CODEMEM && t0_q >= WORD_BITS'(CODE_WORDS)))
						st = ST_BADARG;
					else begin
						ncnt = n_m2;
						if (op_q == OP_DATAMEM) begin
							ndlo = t1_q[SADDR_W-1:0];
							ndhi = t0_q[SADDR_W-1:0];
						end else begin
							nclo = t1_q[CODE_AW-1:0];
							nchi = t0_q[CODE_AW-1:0];
						end
					end
				end
				OP_STARTUSER: begin
					nip   = code_lo_q;
					nmode = 1'b0;
				end
				OP_TERMINATE: st = ST_HALT;
				default:      st = ST_ILLEGAL;
			endcase
		end
		if (st != ST_RUN) nip = ip_q;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ip_q        <= '0;
			dcnt_q      <= '0;
			rcnt_q      <= '0;
			mode_q      <= 1'b1;
			halted_q    <= 1'b0;
			code_lo_q   <= '0;
			code_hi_q   <= '0;
			data_lo_q   <= '0;
			data_hi_q   <= '0;
			svalid_q    <= '0;
		end else begin
			// the start mode bit loads the current mode at once
			if (cfg_we) mode_q <= cfg_data;
			if (cmd.exec) begin
				ip_q      <= nip;
				dcnt_q    <= ncnt;
				rcnt_q    <= nrc;
				mode_q    <= nmode;
				code_lo_q <= nclo;
				code_hi_q <= nchi;
				data_lo_q <= ndlo;
				data_hi_q <= ndhi;
				if (st != ST_RUN) halted_q <= 1'b1;
				if (s_we) svalid_q[t0_q[SADDR_W-1:0]] <= 1'b1;
			end
		end
	end

	// payload, stacks and memories
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op_t'(action);
			iw_q <= inline_word;
			rv_q <= read_value;
		end
		if (cmd.rd_en) rdata_q <= dstk[rd_addr];
		if (cmd.cap0)  t0_q <= rdata_q;
		if (cmd.cap1) begin
			t1_q    <= rdata_q;
			srd_q   <= sstore[t0_q[SADDR_W-1:0]];
			srd_v_q <= svalid_q[t0_q[SADDR_W-1:0]];
		end
		if (cmd.cap2)  t2_q <= rdata_q;
		if (cmd.exec) begin
			if (w1_en)   dstk[w1_addr] <= w1_data;
			if (s_we)    sstore[t0_q[SADDR_W-1:0]] <= t1_q;
			if (rs_push) rstk_q[rcnt_q[RSTK_AW-1:0]] <= ip_q + CODE_AW'(2);
			w2_en_q    <= w2_en;
			w2_addr_q  <= w2_addr;
			w2_data_q  <= w2_data;
			fetch_ip_q <= nip;
			emit_q     <= emit;
			oval_q     <= oval;
			st_q       <= st;
			sup_q      <= nmode;
		end
		if (cmd.wb && w2_en_q) dstk[w2_addr_q] <= w2_data_q;
	end

	assign fetch_ip   = fetch_ip_q;
	assign out_valid  = emit_q;
	assign out_value  = $signed(oval_q);
	assign status     = st_q;
	assign supervisor = sup_q;

`ifndef SYNTHESIS
	a_dcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		dcnt_q <= DCNT_W'(DATA_STACK_DEPTH))
		else $error("data stack count past depth");
	a_rcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		rcnt_q <= RCNT_W'(CALL_STACK_DEPTH))
		else $error("return stack count past depth");
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halted flag cleared");
`endif

endmodule

// ===== hw/rtl/psm_ctrl.sv =====
// ----------------------------------------------------------------------------
// psm_ctrl
// instruction sequencer: operand reads, multiply/divide wait, execute, writeback
// ----------------------------------------------------------------------------
module psm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            res_valid,
	input  logic            res_ready,
	output logic            cfg_ready,
	output psm_pkg::cmd_t   cmd,
	input  psm_pkg::stat_t  stat
);
	import psm_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_RD0, S_RD1, S_RD2, S_RD3, S_MDW, S_EXEC, S_WB
	} state_t;

	state_t state_q;
	logic   res_valid_q;
	logic   exec_go;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign res_valid = res_valid_q;
	assign exec_go   = (state_q == S_EXEC) && (!res_valid_q || res_ready);

	always_comb begin
		cmd          = '0;
		cmd.rd_sel   = RD_TOP;
		cmd.load     = in_valid && in_ready;
		cmd.exec     = exec_go;
		cmd.wb       = (state_q == S_WB);
		cmd.md_start = (state_q == S_RD3) && stat.need_md;
		unique case (state_q)
			S_RD0: cmd.rd_en = 1'b1;
			S_RD1: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_SECOND;
				cmd.cap0   = 1'b1;
			end
			S_RD2: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_THIRD;
				cmd.cap1   = 1'b1;
			end
			S_RD3:   cmd.cap2 = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			if (exec_go)        res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_RD0;
				S_RD0:  state_q <= S_RD1;
				S_RD1:  state_q <= S_RD2;
				S_RD2:  state_q <= S_RD3;
				S_RD3:  state_q <= stat.need_md ? S_MDW : S_EXEC;
				S_MDW:  if (stat.md_done) state_q <= S_EXEC;
				S_EXEC: if (exec_go) state_q <= S_WB;
				S_WB:   state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_RD0))
		else $error("accepted item did not start operand reads");
	a_exec_result: assert property (@(posedge clk) disable iff (!arst_n)
		exec_go |=> res_valid_q)
		else $error("executed item gave no result");
	a_md_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.md_start |=> (state_q == S_MDW && !in_ready))
		else $error("multiply/divide started without interlock");
`endif

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the privileged stack machine core: drives
// instruction items, predicts every result item from an internal copy of the
// machine state and compares them field by field under random idling and
// receiver back-pressure
`timescale 1ns / 1ps

module tb;
	import psm_pkg::*;

	localparam int LIMIT_CYCLES = 1000000;

	typedef struct packed {
		logic [11:0] fetch_ip;
		logic        out_valid;
		logic [63:0] out_value;
		logic [3:0]  status;
		logic        supervisor;
	} outcome_t;

	// dut ports
	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [5:0]  action;
	logic [31:0] inline_word;
	logic [31:0] read_value;
	logic        res_valid;
	logic        res_ready;
	logic [11:0] fetch_ip;
	logic        out_valid;
	logic [63:0] out_value;
	logic [3:0]  status;
	logic        supervisor;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_data;

	// machine image kept by the bench
	logic [63:0] m_dstk [DATA_STACK_DEPTH];
	int          m_dcnt;
	logic [11:0] m_rstk [CALL_STACK_DEPTH];
	int          m_rcnt;
	logic [63:0] m_mem [STATIC_WORDS];
	logic [11:0] m_ip;
	bit          m_mode;
	int          m_clo, m_chi, m_dlo, m_dhi;
	bit          m_halted;

	outcome_t pending_results[$];
	int       mismatches;
	int       idle_pct;
	int       stall_pct;
	longint   cycles;

	privileged_stack_machine_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.inline_word(inline_word),
		.read_value (read_value),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.fetch_ip   (fetch_ip),
		.out_valid  (out_valid),
		.out_value  (out_value),
		.status     (status),
		.supervisor (supervisor),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	// 4 ns clock
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver back-pressure, changed at the falling edge
	always @(negedge clk) begin
		if (arst_n)
			res_ready = ($urandom_range(99) >= stall_pct);
	end

	function automatic bit in_code(longint t);
		return t >= m_clo && t <= m_chi;
	endfunction

	function automatic bit in_data(longint t);
		return t >= m_dlo && t <= m_dhi;
	endfunction

	// two-operand arithmetic and logic, second operand on top
	function automatic logic [63:0] alu_result(logic [5:0] op, logic [63:0] a,
			logic [63:0] b, ref logic [3:0] st);
		longint sa;
		longint sb;
		sa = $signed(a);
		sb = $signed(b);
		case (op)
			OP_ADD: return a + b;
			OP_SUB: return a - b;
			OP_MUL: return a * b;
			OP_DIV, OP_MOD: begin
				if (sb == 0) begin
					st = ST_DIVZ;
					return 64'd0;
				end
				// most negative over minus one wraps, remainder zero
				if (sb == -1)
					return (op == OP_DIV) ? 64'd0 - a : 64'd0;
				return (op == OP_DIV) ? sa / sb : sa % sb;
			end
			OP_SHL: begin
				if (sb < 0 || sb >= WORD_BITS)
					return 64'd0;
				return a << sb;
			end
			OP_SHR: begin
				if (sb < 0 || sb >= WORD_BITS)
					return {64{a[63]}};
				return sa >>> sb;
			end
			OP_AND:    return a & b;
			OP_OR:     return a | b;
			OP_XOR:    return a ^ b;
			OP_LOGAND: return (a != 0 && b != 0) ? 64'd1 : 64'd0;
			default:   return (a != 0 || b != 0) ? 64'd1 : 64'd0;
		endcase
	endfunction

	// execute one instruction on the bench image and return its result item
	function automatic outcome_t execute_instr(logic [5:0] op, logic [31:0] iw_bits,
			logic [31:0] rv_bits);
		outcome_t    o;
		logic [3:0]  st;
		logic [11:0] nip;
		logic [63:0] rv;
		logic [63:0] r;
		longint      iw;
		longint      a;
		longint      b;
		longint      lim;
		int          n;
		int          rc;
		int          d;
		bit          emit;
		logic [63:0] oval;
		st = ST_RUN;
		n = m_dcnt;
		rc = m_rcnt;
		nip = m_ip + 12'd1;
		iw = longint'($signed(iw_bits));
		rv = {{32{rv_bits[31]}}, rv_bits};
		emit = 0;
		oval = 64'd0;
		if (m_halted) begin
			st = ST_HALT;
		end else if (op >= OP_SYSRETURN && op <= OP_TERMINATE && !m_mode) begin
			st = ST_PRIV;
		end else begin
			case (op)
				OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_SHL, OP_SHR, OP_AND, OP_OR,
				OP_XOR, OP_LOGAND, OP_LOGOR: begin
					if (n < 2) st = ST_STACK;
					else begin
						r = alu_result(op, m_dstk[n-2], m_dstk[n-1], st);
						if (st == ST_RUN) begin
							m_dstk[n-2] = r;
							m_dcnt = n - 1;
						end
					end
				end
				OP_COMPLEMENT: begin
					if (n < 1) st = ST_STACK;
					else m_dstk[n-1] = ~m_dstk[n-1];
				end
				OP_LOGNOT: begin
					if (n < 1) st = ST_STACK;
					else m_dstk[n-1] = (m_dstk[n-1] == 0) ? 64'd1 : 64'd0;
				end
				OP_DUP: begin
					if (n < 1 || n + 1 > DATA_STACK_DEPTH) st = ST_STACK;
					else begin
						m_dstk[n] = m_dstk[n-1];
						m_dcnt = n + 1;
					end
				end
				OP_DUP2: begin
					if (n < 1 || n + 2 > DATA_STACK_DEPTH) st = ST_STACK;
					else begin
						m_dstk[n] = m_dstk[n-1];
						m_dstk[n+1] = m_dstk[n-1];
						m_dcnt = n + 2;
					end
				end
				OP_OVER, OP_OVER2: begin
					d = (op == OP_OVER) ? 2 : 3;
					if (n < d || n + 1 > DATA_STACK_DEPTH) st = ST_STACK;
					else begin
						m_dstk[n] = m_dstk[n-d];
						m_dcnt = n + 1;
					end
				end
				OP_SWAP, OP_SWAP2: begin
					d = (op == OP_SWAP) ? 2 : 3;
					if (n < d) st = ST_STACK;
					else begin
						r = m_dstk[n-1];
						m_dstk[n-1] = m_dstk[n-d];
						m_dstk[n-d] = r;
					end
				end
				OP_FETCH: begin
					if (n < 1) st = ST_STACK;
					else begin
						a = $signed(m_dstk[n-1]);
						if (!in_data(a)) st = ST_ADDR;
						else m_dstk[n-1] = m_mem[a[7:0]];
					end
				end
				OP_STORE: begin
					if (n < 2) st = ST_STACK;
					else begin
						a = $signed(m_dstk[n-1]);
						if (!in_data(a)) st = ST_ADDR;
						else begin
							m_mem[a[7:0]] = m_dstk[n-2];
							m_dcnt = n - 2;
						end
					end
				end
				OP_GOTO: begin
					if (!in_code(iw)) st = ST_ADDR;
					else nip = iw[11:0];
				end
				OP_GOTO0: begin
					if (n < 1) st = ST_STACK;
					else if (m_dstk[n-1] == 0) begin
						// only a taken branch is bounds checked
						if (!in_code(iw)) st = ST_ADDR;
						else begin
							nip = iw[11:0];
							m_dcnt = n - 1;
						end
					end else begin
						nip = m_ip + 12'd2;
						m_dcnt = n - 1;
					end
				end
				OP_CALL: begin
					if (rc >= CALL_STACK_DEPTH) st = ST_STACK;
					else if (!in_code(iw)) st = ST_ADDR;
					else begin
						m_rstk[rc] = m_ip + 12'd2;
						m_rcnt = rc + 1;
						nip = iw[11:0];
					end
				end
				OP_RETURN, OP_SYSRETURN: begin
					if (rc < 1) st = ST_STACK;
					else if (!in_code(longint'(m_rstk[rc-1]))) st = ST_ADDR;
					else begin
						nip = m_rstk[rc-1];
						m_rcnt = rc - 1;
						if (op == OP_SYSRETURN) m_mode = 0;
					end
				end
				OP_SYSCALL: begin
					if (n < 1) st = ST_STACK;
					else begin
						a = $signed(m_dstk[n-1]);
						if (a == 0) begin
							m_dstk[n-1] = rv;
							m_mode = 1;
						end else if (a == 1) begin
							if (n < 2) st = ST_STACK;
							else begin
								emit = 1;
								oval = m_dstk[n-2];
								m_dcnt = n - 2;
								m_mode = 1;
							end
						end else if (a == 2) begin
							m_dcnt = n - 1;
							m_mode = 1;
							st = ST_HALT;
						end else begin
							st = ST_BADSYS;
						end
					end
				end
				OP_CONST: begin
					if (n >= DATA_STACK_DEPTH) st = ST_STACK;
					else begin
						m_dstk[n] = iw;
						m_dcnt = n + 1;
						nip = m_ip + 12'd2;
					end
				end
				OP_DROP, OP_DROP2: begin
					d = (op == OP_DROP) ? 1 : 2;
					if (n < d) st = ST_STACK;
					else m_dcnt = n - d;
				end
				OP_INPUT: begin
					if (n >= DATA_STACK_DEPTH) st = ST_STACK;
					else begin
						m_dstk[n] = rv;
						m_dcnt = n + 1;
					end
				end
				OP_OUTPUT: begin
					if (n < 1) st = ST_STACK;
					else begin
						emit = 1;
						oval = m_dstk[n-1];
						m_dcnt = n - 1;
					end
				end
				OP_DATAMEM, OP_CODEMEM: begin
					lim = longint'((op == OP_DATAMEM) ? STATIC_WORDS : CODE_WORDS);
					if (n < 2) st = ST_STACK;
					else begin
						a = $signed(m_dstk[n-2]);
						b = $signed(m_dstk[n-1]);
						if (a > b || a < 0 || b >= lim) st = ST_BADARG;
						else begin
							if (op == OP_DATAMEM) begin
								m_dlo = int'(a);
								m_dhi = int'(b);
							end else begin
								m_clo = int'(a);
								m_chi = int'(b);
							end
							m_dcnt = n - 2;
						end
					end
				end
				OP_STARTUSER: begin
					nip = 12'(m_clo);
					m_mode = 0;
				end
				OP_TERMINATE: st = ST_HALT;
				default:      st = ST_ILLEGAL;
			endcase
		end
		// faults and termination freeze the ip on the instruction
		if (st != ST_RUN) begin
			m_halted = 1;
			nip = m_ip;
		end
		m_ip = nip;
		o.fetch_ip = nip;
		o.out_valid = emit;
		o.out_value = emit ? oval : 64'd0;
		o.status = st;
		o.supervisor = m_mode;
		return o;
	endfunction

	// result checker: every accepted result item against the oldest expectation
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && res_valid && res_ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result item: ip %0d status %0d", fetch_ip, status);
			end else begin
				want = pending_results.pop_front();
				if (fetch_ip !== want.fetch_ip || out_valid !== want.out_valid ||
						out_value !== want.out_value || status !== want.status ||
						supervisor !== want.supervisor) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp ip %0d ov %0b val %h st %0d sup %0b",
							want.fetch_ip, want.out_valid, want.out_value, want.status,
							want.supervisor,
							" / got ip %0d ov %0b val %h st %0d sup %0b",
							fetch_ip, out_valid, out_value, status, supervisor);
				end
			end
		end
	end

	// send one instruction item; called at a falling edge, returns at one
	task automatic send_instr(logic [5:0] op, logic [31:0] iw, logic [31:0] rv);
		while ($urandom_range(99) < idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		action = op;
		inline_word = iw;
		read_value = rv;
		in_valid = 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		pending_results.push_back(execute_instr(op, iw, rv));
		@(negedge clk);
	endtask

	task automatic push_const(logic [31:0] v);
		send_instr(OP_CONST, v, $urandom());
	endtask

	// wait until every result item is back, then a short tail
	task automatic drain_results();
		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_start_mode(logic v);
		cfg_data = v;
		cfg_valid = 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		m_mode = v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [31:0] random_word();
		case ($urandom_range(3))
			0: return $urandom_range(0, 70);
			1: return $urandom();
			2: begin
				case ($urandom_range(3))
					0: return 32'h7fffffff;
					1: return 32'h80000000;
					2: return 32'hffffffff;
					default: return 32'd0;
				endcase
			end
			default: return -$urandom_range(0, 70);
		endcase
	endfunction

	// one well-formed instruction or short sequence that never faults
	task automatic send_safe_step();
		logic [5:0] op;
		int         n;
		bit         done;
		int         lo;
		int         hi;
		op = 6'($urandom_range(0, OP_STARTUSER));
		n = m_dcnt;
		// keep the stack depth wandering without running away
		if (n > 48 && $urandom_range(1) == 1) op = OP_DROP2;
		if (!m_mode && op >= OP_SYSRETURN) op = OP_SYSCALL;
		done = 1;
		case (op)
			OP_ADD, OP_SUB, OP_MUL, OP_SHL, OP_SHR, OP_AND, OP_OR, OP_XOR, OP_LOGAND,
			OP_LOGOR: begin
				if (n >= 2) send_instr(op, $urandom(), $urandom());
				else done = 0;
			end
			OP_DIV, OP_MOD: begin
				if (n >= 2 && m_dstk[n-1] != 0) send_instr(op, $urandom(), $urandom());
				else done = 0;
			end
			OP_COMPLEMENT, OP_LOGNOT, OP_OUTPUT: begin
				if (n >= 1) send_instr(op, $urandom(), $urandom());
				else done = 0;
			end
			OP_DUP: if (n >= 1 && n <= 63) send_instr(op, $urandom(), $urandom()); else done = 0;
			OP_DUP2: if (n >= 1 && n <= 62) send_instr(op, $urandom(), $urandom()); else done = 0;
			OP_OVER: if (n >= 2 && n <= 63) send_instr(op, $urandom(), $urandom()); else done = 0;
			OP_OVER2: if (n >= 3 && n <= 63) send_instr(op, $urandom(), $urandom()); else done = 0;
			OP_SWAP: if (n >= 2) send_instr(op, $urandom(), $urandom()); else done = 0;
			OP_SWAP2: if (n >= 3) send_instr(op, $urandom(), $urandom()); else done = 0;
			OP_FETCH: begin
				if (n <= 62) begin
					push_const($urandom_range(m_dlo, m_dhi));
					send_instr(op, $urandom(), $urandom());
				end else done = 0;
			end
			OP_STORE: begin
				if (n <= 61) begin
					if (n < 1) push_const(random_word());
					push_const($urandom_range(m_dlo, m_dhi));
					send_instr(op, $urandom(), $urandom());
				end else done = 0;
			end
			OP_GOTO: send_instr(op, $urandom_range(m_clo, m_chi), $urandom());
			OP_GOTO0: begin
				if (n >= 1) begin
					// a branch not taken may carry any target
					if (m_dstk[n-1] == 0 || $urandom_range(1) == 1)
						send_instr(op, (m_dstk[n-1] == 0) ? $urandom_range(m_clo, m_chi)
							: $urandom(), $urandom());
					else
						send_instr(op, $urandom(), $urandom());
				end else if (n < 63) begin
					push_const(32'd0);
					send_instr(op, $urandom_range(m_clo, m_chi), $urandom());
				end else done = 0;
			end
			OP_CALL: begin
				if (m_rcnt < CALL_STACK_DEPTH)
					send_instr(op, $urandom_range(m_clo, m_chi), $urandom());
				else done = 0;
			end
			OP_RETURN, OP_SYSRETURN: begin
				if (m_rcnt >= 1 && in_code(longint'(m_rstk[m_rcnt-1])))
					send_instr(op, $urandom(), $urandom());
				else done = 0;
			end
			OP_SYSCALL: begin
				if (n <= 62) begin
					if (n >= 1 && $urandom_range(1) == 1) begin
						push_const(32'd1);
					end else begin
						push_const(32'd0);
					end
					send_instr(op, $urandom(), $urandom());
				end else done = 0;
			end
			OP_CONST, OP_INPUT: begin
				if (n < DATA_STACK_DEPTH) send_instr(op, random_word(), random_word());
				else done = 0;
			end
			OP_DROP: if (n >= 1) send_instr(op, $urandom(), $urandom()); else done = 0;
			OP_DROP2: if (n >= 2) send_instr(op, $urandom(), $urandom()); else done = 0;
			OP_DATAMEM, OP_CODEMEM: begin
				if (n <= 62) begin
					hi = (op == OP_DATAMEM) ? STATIC_WORDS - 1 : CODE_WORDS - 1;
					// half the time open the whole range again
					if ($urandom_range(1) == 1) lo = 0;
					else begin
						lo = $urandom_range(0, hi);
						hi = $urandom_range(lo, hi);
					end
					push_const(lo);
					push_const(hi);
					send_instr(op, $urandom(), $urandom());
				end else done = 0;
			end
			default: send_instr(OP_STARTUSER, $urandom(), $urandom());
		endcase
		if (!done) begin
			if (m_dcnt < 32) push_const(random_word());
			else send_instr(OP_DROP, $urandom(), $urandom());
		end
	endtask

	// bounds, wraparound of divide, a shift out of range, complement, lognot,
	// field extremes
	task automatic test_directed();
		push_const(32'd0);
		push_const(32'd255);
		send_instr(OP_DATAMEM, 32'd0, 32'd0);
		push_const(32'd0);
		push_const(32'd4095);
		send_instr(OP_CODEMEM, 32'hffffffff, 32'hffffffff);
		push_const(32'd1);
		push_const(32'd63);
		send_instr(OP_SHL, 32'd0, 32'd0);
		push_const(32'hffffffff);
		send_instr(OP_DIV, 32'd0, 32'd0);
		push_const(32'hffffffff);
		send_instr(OP_MOD, 32'd0, 32'd0);
		send_instr(OP_COMPLEMENT, 32'd0, 32'd0);
		send_instr(OP_LOGNOT, 32'd0, 32'd0);
		send_instr(OP_DROP, 32'd0, 32'd0);
		push_const(32'hfffffff8);
		push_const(32'd64);
		send_instr(OP_SHR, 32'd0, 32'd0);
		send_instr(OP_OUTPUT, 32'd0, 32'd0);
		send_instr(OP_INPUT, 32'h7fffffff, 32'h80000000);
		send_instr(OP_INPUT, 32'h80000000, 32'h7fffffff);
		send_instr(OP_ADD, 32'd0, 32'd0);
		send_instr(OP_OUTPUT, 32'd0, 32'd0);
		drain_results();
	endtask

	// well-formed random programs under one idling, stall and start mode setting
	task automatic test_random_phase(int items, int idle, int stall, logic mode);
		int start_count;
		idle_pct = idle;
		stall_pct = stall;
		write_start_mode(mode);
		start_count = 0;
		while (start_count < items) begin
			send_safe_step();
			start_count++;
			// sender waits once for the pipeline to empty
			if (start_count == items / 2) drain_results();
		end
		drain_results();
	endtask

	// one fault or termination, then items into the halted core
	task automatic test_fault_and_halt();
		int kind;
		int i;
		idle_pct = 27;
		stall_pct = 27;
		if (m_dcnt >= 62) send_instr(OP_DROP2, 32'd0, 32'd0);
		kind = $urandom_range(0, 9);
		case (kind)
			0: send_instr(6'($urandom_range(OP_TERMINATE + 1, 63)), $urandom(), $urandom());
			1: send_instr(OP_TERMINATE, $urandom(), $urandom());
			2: begin
				drain_results();
				write_start_mode(1'b0);
				send_instr(OP_INPUT, $urandom(), $urandom());
			end
			3: send_instr(OP_GOTO, -$urandom_range(1, 1000), $urandom());
			4: begin
				push_const(32'hfffffffb);
				send_instr(OP_FETCH, $urandom(), $urandom());
			end
			5: begin
				push_const($urandom());
				push_const(32'd0);
				send_instr(OP_DIV, $urandom(), $urandom());
			end
			6: begin
				push_const($urandom_range(3, 1000));
				send_instr(OP_SYSCALL, $urandom(), $urandom());
			end
			7: begin
				push_const(32'd10);
				push_const(32'd3);
				send_instr(OP_DATAMEM, $urandom(), $urandom());
			end
			8: begin
				while (m_dcnt > 0) send_instr(OP_DROP, $urandom(), $urandom());
				send_instr(OP_DROP, $urandom(), $urandom());
			end
			default: begin
				push_const(32'd2);
				send_instr(OP_SYSCALL, $urandom(), $urandom());
			end
		endcase
		for (i = 0; i < 8; i++)
			send_instr(6'($urandom_range(0, 63)), $urandom(), $urandom());
		drain_results();
	endtask

	initial begin
		int i;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = '0;
		inline_word = '0;
		read_value = '0;
		res_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		cycles = 0;
		mismatches = 0;
		idle_pct = 0;
		stall_pct = 0;
		// reset image of the machine
		for (i = 0; i < DATA_STACK_DEPTH; i++) m_dstk[i] = '0;
		for (i = 0; i < CALL_STACK_DEPTH; i++) m_rstk[i] = '0;
		for (i = 0; i < STATIC_WORDS; i++) m_mem[i] = '0;
		m_dcnt = 0;
		m_rcnt = 0;
		m_ip = '0;
		m_mode = 1;
		m_clo = 0;
		m_chi = 0;
		m_dlo = 0;
		m_dhi = 0;
		m_halted = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		write_start_mode(1'b1);
		test_directed();
		test_random_phase(130, 0, 0, 1'b1);
		test_random_phase(130, 83, 0, 1'b0);
		test_random_phase(130, 0, 83, 1'b1);
		test_random_phase(130, 27, 27, 1'b0);
		test_fault_and_halt();

		repeat (20) @(negedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/psm_pkg.sv
hw/rtl/psm_muldiv.sv
hw/rtl/psm_dp.sv
hw/rtl/psm_ctrl.sv
hw/rtl/privileged_stack_machine_core.sv
tb/tb.sv
